>>> rtl/bpl_pkg.sv
// Shared definitions for the buffer pool with linked queue.
// Holds opcode and status codes and the fixed field widths; no dependencies.
package bpl_pkg;

  localparam int BPL_OP_W  = 2;
  localparam int BPL_IDX_W = 5;

  typedef logic [BPL_OP_W-1:0] bpl_op_t;

  localparam bpl_op_t OP_ALLOC = 2'd0;
  localparam bpl_op_t OP_FREE  = 2'd1;
  localparam bpl_op_t OP_ENQ   = 2'd2;
  localparam bpl_op_t OP_DEQ   = 2'd3;

  localparam logic ST_DONE  = 1'b0;
  localparam logic ST_EMPTY = 1'b1;

endpackage

>>> rtl/bpl_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; used for the link store of the buffer pool.
module bpl_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/buffer_pool_with_linked_queue_core.sv
// Top level of the buffer pool with one linked FIFO queue.
// Depends on bpl_pkg and bpl_ram (link store).
//
// The block hands out and takes back buffers named by index and keeps one FIFO
// queue of buffers, both threaded through a single link RAM. Opcodes: allocate
// pops the free list, free pushes a buffer onto it, enqueue links a buffer
// after the queue tail, dequeue pops the queue head; allocate or dequeue on an
// empty list answers index 0 with status 1. Free and enqueue of an index at or
// above POOL_BUFFERS are ignored. Double frees are not detected. After reset
// the block chains the link RAM (entry i to i+1, last to none) and holds
// in_ready low during that pass. Then each transaction is accepted in a cycle
// that issues the link read and finishes in the execute state, which uses the
// registered read data, writes the link RAM and updates the head pointers.
// An enqueue onto a non-empty queue adds a link state: its two link writes
// share the single RAM write port. A finished result sits in the output
// register while the next transaction is accepted; a transaction whose result
// cannot be placed holds in its execute cycle until out_ready frees the slot.
module buffer_pool_with_linked_queue_core
  import bpl_pkg::*;
#(
  parameter int POOL_BUFFERS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BPL_OP_W-1:0]  in_opcode,
  input  logic [BPL_IDX_W-1:0] in_buffer_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BPL_IDX_W-1:0] out_result_index,
  output logic                 out_status
);

  // Pointer width holds every buffer index plus the "none" value.
  localparam int AW    = $clog2(POOL_BUFFERS);
  localparam int PTR_W = $clog2(POOL_BUFFERS + 1);
  localparam int CW    = (PTR_W > BPL_IDX_W) ? PTR_W : BPL_IDX_W;
  localparam logic [PTR_W-1:0] NONE_PTR = PTR_W'(POOL_BUFFERS);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(POOL_BUFFERS - 1);

  localparam logic [1:0] S_INIT = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_LINK = 2'd3;

  function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
    return p < NONE_PTR;
  endfunction

  logic [1:0]       state_r, state_nxt;
  logic [PTR_W-1:0] init_cnt_r, init_cnt_nxt;
  logic [PTR_W-1:0] free_head_r, free_head_nxt;
  logic [PTR_W-1:0] queue_head_r, queue_head_nxt;
  logic [PTR_W-1:0] queue_tail_r, queue_tail_nxt;
  bpl_op_t          op_r;
  logic [PTR_W-1:0] buf_r;
  logic             buf_ok_r;

  logic                 out_valid_r, out_valid_nxt;
  logic [BPL_IDX_W-1:0] out_index_r, out_index_nxt;
  logic                 out_status_r, out_status_nxt;

  // Link RAM ports
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [PTR_W-1:0] ram_wdata, ram_rdata;

  logic             in_fire, done;
  logic [CW-1:0]    in_buf_ext, res_ext;
  logic [PTR_W-1:0] rd_ptr, res_ptr;
  logic             res_status;

  assign in_ready   = (state_r == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign in_buf_ext = CW'(in_buffer_index);

  // Execute completes only when the output slot is free or being drained.
  assign done = (state_r == S_EXEC) && (!out_valid_r || out_ready);

  // Fetch the link word of the head that the operation pops.
  assign rd_ptr    = (in_opcode == OP_ALLOC) ? free_head_r : queue_head_r;
  assign ram_re    = in_fire;
  assign ram_raddr = rd_ptr[AW-1:0];

  always_comb begin
    state_nxt      = state_r;
    init_cnt_nxt   = init_cnt_r;
    free_head_nxt  = free_head_r;
    queue_head_nxt = queue_head_r;
    queue_tail_nxt = queue_tail_r;
    ram_we         = 1'b0;
    ram_waddr      = buf_r[AW-1:0];
    ram_wdata      = NONE_PTR;
    res_ptr        = '0;
    res_status     = ST_DONE;

    case (state_r)
      S_INIT: begin
        // Chain entry i to i+1; the last entry lands on the none value.
        ram_we       = 1'b1;
        ram_waddr    = init_cnt_r[AW-1:0];
        ram_wdata    = init_cnt_r + PTR_W'(1);
        init_cnt_nxt = init_cnt_r + PTR_W'(1);
        if (init_cnt_r == LAST_PTR) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_nxt = S_IDLE;
          case (op_r)
            OP_ALLOC: begin
              if (ptr_ok(free_head_r)) begin
                free_head_nxt = ram_rdata;
                res_ptr       = free_head_r;
              end else begin
                res_status = ST_EMPTY;
              end
            end
            OP_FREE: begin
              if (buf_ok_r) begin
                ram_we        = 1'b1;
                ram_wdata     = free_head_r;
                free_head_nxt = buf_r;
              end
            end
            OP_ENQ: begin
              if (buf_ok_r) begin
                queue_tail_nxt = buf_r;
                if (!ptr_ok(queue_head_r)) begin
                  queue_head_nxt = buf_r;
                  ram_we         = 1'b1;
                end else if (ptr_ok(queue_tail_r)) begin
                  // Link old tail first; terminate the new buffer next cycle.
                  ram_we    = 1'b1;
                  ram_waddr = queue_tail_r[AW-1:0];
                  ram_wdata = buf_r;
                  state_nxt = S_LINK;
                end else begin
                  ram_we = 1'b1;
                end
              end
            end
            default: begin
              if (ptr_ok(queue_head_r)) begin
                queue_head_nxt = ram_rdata;
                res_ptr        = queue_head_r;
              end else begin
                res_status = ST_EMPTY;
              end
            end
          endcase
        end
      end
      default: begin
        // Terminate the newly enqueued buffer.
        ram_we    = 1'b1;
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign res_ext = CW'(res_ptr);

  // Output register: load on completion, drop on acceptance.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_index_nxt  = out_index_r;
    out_status_nxt = out_status_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (done) begin
      out_valid_nxt  = 1'b1;
      out_index_nxt  = res_ext[BPL_IDX_W-1:0];
      out_status_nxt = res_status;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      init_cnt_r   <= '0;
      free_head_r  <= '0;
      queue_head_r <= NONE_PTR;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      init_cnt_r   <= init_cnt_nxt;
      free_head_r  <= free_head_nxt;
      queue_head_r <= queue_head_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    queue_tail_r <= queue_tail_nxt;
    out_index_r  <= out_index_nxt;
    out_status_r <= out_status_nxt;
    if (in_fire) begin
      op_r     <= in_opcode;
      buf_r    <= PTR_W'(in_buf_ext);
      buf_ok_r <= in_buf_ext < CW'(POOL_BUFFERS);
    end
  end

  bpl_ram #(
    .WIDTH(PTR_W),
    .DEPTH(POOL_BUFFERS)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_status       = out_status_r;

  // An empty answer never carries an index.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> (out_index_r == '0))
    else $error("empty status with nonzero index");

  // A link read never collides with a link write.
  a_no_rw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(ram_we && ram_re))
    else $error("link RAM read and write in the same cycle");

  // An accepted transaction moves straight to execute.
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_EXEC))
    else $error("accepted transaction did not enter execute");

  // A stalled execute leaves the list heads untouched.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && out_valid_r && !out_ready) |=>
      ($stable(free_head_r) && $stable(queue_head_r)))
    else $error("heads changed while result slot was full");

endmodule
